[sv/amp_pkg.sv]
// Shared constants and register codes for the autoranging moisture pump controller.
package amp_pkg;

  // Default raw sample width.
  localparam int SAMPLE_BITS_DEF = 12;

  // Moisture result, hundredths of a percent.
  localparam int                MOIST_W    = 14;
  localparam logic [MOIST_W-1:0] MOIST_FULL = 14'd10000;

  // Quotient bits produced by the divider, one per step.
  localparam int QUO_W    = MOIST_W;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  // Threshold registers, whole percent.
  localparam int             PCT_W       = 7;
  localparam int             PCT_SCALE   = 100;
  localparam logic [PCT_W-1:0] ON_PCT_RST  = 7'd30;
  localparam logic [PCT_W-1:0] OFF_PCT_RST = 7'd50;

  // Configuration register indexes.
  localparam int                  CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PUMP_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUMP_OFF = 2'd1;

endpackage

[sv/amp_if.sv]
// Channel interfaces of the moisture pump controller: sample in, result out, config write.
interface amp_in_if #(
  parameter int SAMPLE_BITS = amp_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface amp_out_if #(
  parameter int SAMPLE_BITS = amp_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [amp_pkg::MOIST_W-1:0] moisture_centi_pct;
  logic                        pump_on;
  logic [SAMPLE_BITS-1:0]      range_low;
  logic [SAMPLE_BITS-1:0]      range_high;

  modport source (output valid, output moisture_centi_pct, output pump_on,
                  output range_low, output range_high, input ready);
  modport sink   (input valid, input moisture_centi_pct, input pump_on,
                  input range_low, input range_high, output ready);
endinterface

interface amp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [amp_pkg::CFG_IDX_W-1:0] index;
  logic [amp_pkg::PCT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/autoranging_moisture_pump_control.sv]
// Top level of the autoranging soil moisture pump controller.
//
// Use: raw ADC samples arrive on in_chan_i; a zero sample is dropped at once
// with no result and ready stays high. A nonzero sample widens the tracked
// [low, high] range, then moisture = (high - sample) * 10000 / (high - low)
// in hundredths of a percent is worked out, and a hysteresis flag drives the
// pump: on below the on threshold, off at or above the off threshold.
// Each result leaves on res_chan_o with the flag and the updated range.
// Thresholds are written on cfg_chan_i (index 0: on, index 1: off, whole
// percent); writes to other indexes are dropped. The port is always ready.
// Sequence: a multiply step, fourteen restoring-divider steps of a shared
// subtractor (one quotient bit each) and a finishing step; in_chan_i stays
// not ready from the sample transfer until the result is loaded into the
// output register, so a new sample waits until the last one is through.
// A result waits in the output register while the receiver stalls; the next
// sample is still taken and worked on, and only its finishing step waits.
// Reset: thresholds 30 % and 50 %, range 0.8 V to 1.8 V of a 3.3 V full
// scale, pump off, no result pending.
module autoranging_moisture_pump_control #(
  parameter int SAMPLE_BITS = amp_pkg::SAMPLE_BITS_DEF
) (
  input logic            clk_i,
  input logic            rst_ni,
  amp_in_if.sink         in_chan_i,
  amp_out_if.source      res_chan_o,
  amp_cfg_if.sink        cfg_chan_i
);

  localparam int MOIST_W   = amp_pkg::MOIST_W;
  localparam int QUO_W     = amp_pkg::QUO_W;
  localparam int CNT_W     = amp_pkg::DIV_CNT_W;
  localparam int PCT_W     = amp_pkg::PCT_W;
  localparam int PROD_W    = SAMPLE_BITS + QUO_W;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  // Reset bounds: 0.8 V and 1.8 V of 3.3 V, rounded to the nearest count.
  localparam logic [SAMPLE_BITS-1:0] LOW_RST  = SAMPLE_BITS'((SAMPLE_MAX * 16 + 33) / 66);
  localparam logic [SAMPLE_BITS-1:0] HIGH_RST = SAMPLE_BITS'((SAMPLE_MAX * 36 + 33) / 66);
  localparam logic [CNT_W-1:0]       LAST_STEP = CNT_W'(QUO_W - 1);

  // Sequencer codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [PCT_W-1:0]       on_pct_q, off_pct_q;
  logic [SAMPLE_BITS-1:0] low_q, low_d, high_q, high_d;
  logic                   pump_q, pump_d;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [SAMPLE_BITS-1:0] span_q;
  logic                   span_zero_q;
  logic [SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]       quo_q, quo_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   out_vld_q, out_vld_d;
  logic [MOIST_W-1:0]     out_moist_q;
  logic                   out_pump_q;
  logic [SAMPLE_BITS-1:0] out_low_q, out_high_q;

  logic                   in_xfer;
  logic                   out_free;
  logic                   out_load;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS:0]   trial;
  logic [MOIST_W-1:0]     moist;
  logic [MOIST_W-1:0]     on_thr, off_thr;

  assign in_chan_i.ready  = (state_q == ST_IDLE);
  assign in_xfer          = in_chan_i.valid && in_chan_i.ready;
  assign cfg_chan_i.ready = 1'b1;

  assign out_free = !out_vld_q || res_chan_o.ready;
  assign out_load = (state_q == ST_FIN) && out_free;

  // Shared datapath pieces.
  assign prod  = PROD_W'(high_q - smp_q) * PROD_W'(amp_pkg::MOIST_FULL);
  assign trial = {rem_q, quo_q[QUO_W-1]} - {1'b0, span_q};
  assign moist = span_zero_q ? '0 : quo_q;
  assign on_thr  = MOIST_W'(on_pct_q * amp_pkg::PCT_SCALE);
  assign off_thr = MOIST_W'(off_pct_q * amp_pkg::PCT_SCALE);

  always_comb begin
    state_d = state_q;
    low_d   = low_q;
    high_d  = high_q;
    pump_d  = pump_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        // Drop zero samples; widen the range for the rest.
        if (in_xfer && (in_chan_i.sample != '0)) begin
          if (in_chan_i.sample > high_q) begin
            high_d = in_chan_i.sample;
          end else if (in_chan_i.sample < low_q) begin
            low_d = in_chan_i.sample;
          end
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // Upper bits seed the remainder; the quotient cannot exceed QUO_W bits.
        rem_d   = prod[PROD_W-1:QUO_W];
        quo_d   = prod[QUO_W-1:0];
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!trial[SAMPLE_BITS]) begin
          rem_d = trial[SAMPLE_BITS-1:0];
        end else begin
          rem_d = {rem_q[SAMPLE_BITS-2:0], quo_q[QUO_W-1]};
        end
        quo_d = {quo_q[QUO_W-2:0], !trial[SAMPLE_BITS]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free; on test wins over off test.
        if (out_free) begin
          if (moist < on_thr) begin
            pump_d = 1'b1;
          end else if (moist >= off_thr) begin
            pump_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (res_chan_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      on_pct_q  <= amp_pkg::ON_PCT_RST;
      off_pct_q <= amp_pkg::OFF_PCT_RST;
      low_q     <= LOW_RST;
      high_q    <= HIGH_RST;
      pump_q    <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      low_q     <= low_d;
      high_q    <= high_d;
      pump_q    <= pump_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
      if (cfg_chan_i.valid && cfg_chan_i.ready) begin
        unique case (cfg_chan_i.index)
          amp_pkg::CFG_PUMP_ON:  on_pct_q  <= cfg_chan_i.data;
          amp_pkg::CFG_PUMP_OFF: off_pct_q <= cfg_chan_i.data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (in_xfer) begin
      smp_q <= in_chan_i.sample;
    end
    if (state_q == ST_MUL) begin
      span_q      <= high_q - low_q;
      span_zero_q <= (high_q <= low_q);
    end
    if (out_load) begin
      out_moist_q <= moist;
      out_pump_q  <= pump_d;
      out_low_q   <= low_q;
      out_high_q  <= high_q;
    end
  end

  assign res_chan_o.valid              = out_vld_q;
  assign res_chan_o.moisture_centi_pct = out_moist_q;
  assign res_chan_o.pump_on            = out_pump_q;
  assign res_chan_o.range_low          = out_low_q;
  assign res_chan_o.range_high         = out_high_q;

endmodule

[sv/amp_checker.sv]
// Port-level checks for the moisture pump controller, bound to the top level.
module amp_checker #(
  parameter int SAMPLE_BITS = amp_pkg::SAMPLE_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [SAMPLE_BITS-1:0]      in_sample_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [amp_pkg::MOIST_W-1:0] out_moist_i,
  input logic                        out_pump_i,
  input logic [SAMPLE_BITS-1:0]      out_low_i,
  input logic [SAMPLE_BITS-1:0]      out_high_i
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_moist_i) && $stable(out_pump_i)
      && $stable(out_low_i) && $stable(out_high_i))
    else $error("result changed while stalled");

  a_moist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_moist_i <= amp_pkg::MOIST_FULL)
    else $error("moisture above full scale");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_low_i < out_high_i)
    else $error("tracked range inverted");

  // A nonzero sample occupies the sequencer; a zero one does not.
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_sample_i != '0) |=> !in_ready_i)
    else $error("took a sample while busy");

  a_zero_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_sample_i == '0) |=> in_ready_i)
    else $error("zero sample not dropped");

endmodule

bind autoranging_moisture_pump_control amp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_amp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan_i.valid),
  .in_ready_i  (in_chan_i.ready),
  .in_sample_i (in_chan_i.sample),
  .out_valid_i (res_chan_o.valid),
  .out_ready_i (res_chan_o.ready),
  .out_moist_i (res_chan_o.moisture_centi_pct),
  .out_pump_i  (res_chan_o.pump_on),
  .out_low_i   (res_chan_o.range_low),
  .out_high_i  (res_chan_o.range_high)
);
